/* hw/rtl/qmm_pkg.sv */
// ----------------------------------------------------------------------------
// qmm_pkg
// Types and fixed widths shared by the quad motor mixer pipeline.
// ----------------------------------------------------------------------------
package qmm_pkg;

  localparam int FRAC_BITS = 13;  // fraction bits of every fixed-point value

  localparam int MW = 18;  // mix width, signed
  localparam int QW = 18;  // quotient bits of the scale divider
  localparam int NW = 32;  // dividend width
  localparam int DW = 18;  // divisor (spread) width
  localparam int LW = 15;  // range limit width
  localparam int IW = 14;  // idle level and result width

  localparam logic [1:0] REG_RANGE_LIMIT = 2'd0;
  localparam logic [1:0] REG_IDLE_LEVEL  = 2'd1;
  localparam logic [1:0] REG_ALLOW_RAISE = 2'd2;
  localparam logic [1:0] REG_YAW_NEGATE  = 2'd3;

  typedef struct packed {
    logic        publish_request;
    logic        motors_stop;
    logic        inverted_flight;
    logic [15:0] yaw_corr;
    logic [15:0] pitch_corr;
    logic [15:0] roll_corr;
    logic [14:0] throttle_cmd;
  } in_t;

  // Items that bypass the divider
  typedef struct packed {
    logic [3:0][MW-1:0] m;
    logic [3:0]         neg;
    logic               scale;
    logic [MW:0]        shift_plain;
    logic               stop;
    logic               pub;
  } side_t;

  typedef struct packed {
    logic [3:0][MW-1:0] rem;
    logic [3:0][QW-1:0] num;
    logic [3:0][QW-1:0] q;
    logic [DW-1:0]      d;
    side_t              side;
  } div_st_t;

  typedef struct packed {
    logic          publish;
    logic [IW-1:0] largest_motor;
    logic [IW-1:0] average_thrust;
    logic [IW-1:0] back_left;
    logic [IW-1:0] back_right;
    logic [IW-1:0] front_left;
    logic [IW-1:0] front_right;
  } res_t;

endpackage

/* hw/rtl/quad_motor_mixer_scaling.sv */
// ----------------------------------------------------------------------------
// quad_motor_mixer_scaling
// X-frame quad motor mixer with range scaling, idle mapping, mean and max.
// ----------------------------------------------------------------------------
// One item in, one item out, at a sustained rate of one per clock while the
// result side does not stall. The pipeline has three front stages (mix, range
// statistics, dividend products), 18 divider stages that form the limit/spread
// scaled mixes one quotient bit per stage, and four back stages (selection,
// shift and clamp, idle mapping, mean and max into the output register). Each
// stage holds its item while the one after it is full and stalled, so back
// pressure reaches back along the combinational ready chain and bubbles are squeezed out.
// Configuration writes are always taken (cfg_ready is high) and must be
// made only while the pipeline is empty.
module quad_motor_mixer_scaling (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // throttle_cmd, roll_corr, pitch_corr, yaw_corr, pad
  input  logic [2:0]  s_tuser,  // inverted_flight, motors_stop, publish_request
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,  // front_right, front_left, back_right, back_left,
                                // average_thrust, largest_motor, pad
  output logic [0:0]  m_tuser   // publish
);
  import qmm_pkg::*;

  logic [LW-1:0] lim;
  logic [IW-1:0] idle_level;
  logic          allow_raise;
  logic          yaw_neg;
  in_t           in_data;
  div_st_t       mix_data, div_data;
  res_t          res;
  logic          mix_valid, mix_ready, div_valid, div_ready;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      lim         <= LW'(8192);
      idle_level  <= '0;
      allow_raise <= 1'b0;
      yaw_neg     <= 1'b0;
    end else if (cfg_valid && cfg_addr[7:2] == '0) begin
      unique case (cfg_addr[1:0])
        REG_RANGE_LIMIT: lim         <= cfg_data[LW-1:0];
        REG_IDLE_LEVEL:  idle_level  <= cfg_data[IW-1:0];
        REG_ALLOW_RAISE: allow_raise <= cfg_data[0];
        REG_YAW_NEGATE:  yaw_neg     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpack the input item
  assign in_data.throttle_cmd    = s_tdata[14:0];
  assign in_data.roll_corr       = s_tdata[30:15];
  assign in_data.pitch_corr      = s_tdata[46:31];
  assign in_data.yaw_corr        = s_tdata[62:47];
  assign in_data.inverted_flight = s_tuser[0];
  assign in_data.motors_stop     = s_tuser[1];
  assign in_data.publish_request = s_tuser[2];

  qmm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .lim       (lim),
    .yaw_neg   (yaw_neg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_data),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_data  (mix_data)
  );

  qmm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_data   (mix_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  qmm_out u_out (
    .clk         (clk),
    .rst         (rst),
    .allow_raise (allow_raise),
    .idle_level  (idle_level),
    .in_valid    (div_valid),
    .in_ready    (div_ready),
    .in_data     (div_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (res)
  );

  // Pack the result item
  assign m_tdata = {4'b0, res.largest_motor, res.average_thrust, res.back_left,
                    res.back_right, res.front_left, res.front_right};
  assign m_tuser = res.publish;

endmodule

/* hw/rtl/qmm_mix.sv */
// ----------------------------------------------------------------------------
// qmm_mix
// Front stages: X-frame mix, range statistics, and scale dividend products.
// ----------------------------------------------------------------------------
module qmm_mix (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [qmm_pkg::LW-1:0]  lim,
  input  logic                    yaw_neg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  qmm_pkg::in_t            in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output qmm_pkg::div_st_t        out_data
);
  import qmm_pkg::*;

  logic                v1, v2, v3;
  logic                rdy1, rdy2, rdy3;
  logic [3:0][MW-1:0]  m1;
  logic                stop1, pub1;
  logic [3:0][MW-1:0]  m2, abs2;
  logic [3:0]          neg2;
  logic [DW-1:0]       spread2;
  logic                scale2, stop2, pub2;
  logic [MW:0]         shift2;
  logic [3:0][NW-1:0]  a3;
  logic [DW-1:0]       d3;
  side_t               side3;

  logic signed [MW-1:0] thr, r, p, y;
  logic [3:0][MW-1:0]   m_next;
  logic signed [MW-1:0] lo, hi, lo01, lo23, hi01, hi23;
  logic signed [MW:0]   spread_s, shift_s;
  logic [3:0][MW-1:0]   abs_next;
  logic [3:0]           neg_next;
  logic [3:0][NW-1:0]   a_next;
  logic [MW+LW-1:0]     prod [4];

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Mix with the normal or inverted sign pattern
  always_comb begin
    thr = MW'(in_data.throttle_cmd);
    r   = MW'($signed(in_data.roll_corr));
    p   = MW'($signed(in_data.pitch_corr));
    y   = MW'($signed(in_data.yaw_corr));
    if (yaw_neg) begin
      y = -y;
    end
    if (in_data.inverted_flight) begin
      m_next[0] = thr + r + p - y;
      m_next[1] = thr - r + p + y;
      m_next[2] = thr + r - p + y;
      m_next[3] = thr - r - p - y;
    end else begin
      m_next[0] = thr - r - p + y;
      m_next[1] = thr + r - p - y;
      m_next[2] = thr - r + p - y;
      m_next[3] = thr + r + p + y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      m1    <= m_next;
      stop1 <= in_data.motors_stop;
      pub1  <= in_data.publish_request;
    end
  end

  // Find extremes, spread and the unscaled shift
  always_comb begin
    lo01 = ($signed(m1[0]) < $signed(m1[1])) ? $signed(m1[0]) : $signed(m1[1]);
    lo23 = ($signed(m1[2]) < $signed(m1[3])) ? $signed(m1[2]) : $signed(m1[3]);
    hi01 = ($signed(m1[0]) > $signed(m1[1])) ? $signed(m1[0]) : $signed(m1[1]);
    hi23 = ($signed(m1[2]) > $signed(m1[3])) ? $signed(m1[2]) : $signed(m1[3]);
    lo   = (lo01 < lo23) ? lo01 : lo23;
    hi   = (hi01 > hi23) ? hi01 : hi23;
    spread_s = (MW+1)'(hi) - (MW+1)'(lo);
    if (hi > $signed({{(MW-LW){1'b0}}, lim})) begin
      shift_s = (MW+1)'(hi) - $signed({{(MW+1-LW){1'b0}}, lim});
    end else if (lo < 0) begin
      shift_s = (MW+1)'(lo);
    end else begin
      shift_s = '0;
    end
    for (int i = 0; i < 4; i++) begin
      abs_next[i] = m1[i][MW-1] ? (MW)'(-$signed(m1[i])) : m1[i];
      neg_next[i] = m1[i][MW-1] && (lim != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      m2      <= m1;
      abs2    <= abs_next;
      neg2    <= neg_next;
      spread2 <= spread_s[DW-1:0];
      scale2  <= spread_s > $signed({{(MW+1-LW){1'b0}}, lim});
      shift2  <= shift_s;
      stop2   <= stop1;
      pub2    <= pub1;
    end
  end

  // Form the magnitude dividend, one below for negative mixes (floor)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i]   = abs2[i] * (MW+LW)'(lim);
      a_next[i] = prod[i][NW-1:0] - NW'(neg2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      a3                <= a_next;
      d3                <= spread2;
      side3.m           <= m2;
      side3.neg         <= neg2;
      side3.scale       <= scale2;
      side3.shift_plain <= shift2;
      side3.stop        <= stop2;
      side3.pub         <= pub2;
    end
  end

  // Seed the divider: high bits as remainder, low bits to shift in
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      out_data.rem[i] = MW'(a3[i][NW-1:QW]);
      out_data.num[i] = a3[i][QW-1:0];
      out_data.q[i]   = '0;
    end
    out_data.d    = d3;
    out_data.side = side3;
  end
  assign out_valid = v3;

endmodule

/* hw/rtl/qmm_div.sv */
// ----------------------------------------------------------------------------
// qmm_div
// Four-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module qmm_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  qmm_pkg::div_st_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output qmm_pkg::div_st_t out_data
);
  import qmm_pkg::*;

  div_st_t    st  [QW+1];
  div_st_t    nx  [QW+1];
  logic       vld [QW+1];
  logic       rdy [QW+2];

  assign st[0]       = in_data;
  assign vld[0]      = in_valid;
  assign rdy[QW+1]   = out_ready;
  assign in_ready    = rdy[1];
  assign out_valid   = vld[QW];
  assign out_data    = st[QW];

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [MW:0] r2 [4];
    logic        ge [4];

    assign rdy[k] = !vld[k] || rdy[k+1];

    // Shift in one dividend bit and try to subtract the divisor
    always_comb begin
      nx[k] = st[k-1];
      for (int i = 0; i < 4; i++) begin
        r2[i]        = {st[k-1].rem[i], st[k-1].num[i][QW-1]};
        ge[i]        = r2[i] >= {1'b0, st[k-1].d};
        nx[k].rem[i] = ge[i] ? MW'(r2[i] - {1'b0, st[k-1].d}) : MW'(r2[i]);
        nx[k].num[i] = {st[k-1].num[i][QW-2:0], 1'b0};
        nx[k].q[i]   = {st[k-1].q[i][QW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
      if (rdy[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  assign nx[0] = st[0];

endmodule

/* hw/rtl/qmm_out.sv */
// ----------------------------------------------------------------------------
// qmm_out
// Back stages: select scaled mix, shift, clamp, idle mapping, mean and max.
// ----------------------------------------------------------------------------
module qmm_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   allow_raise,
  input  logic [qmm_pkg::IW-1:0] idle_level,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  qmm_pkg::div_st_t       in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output qmm_pkg::res_t          out_data
);
  import qmm_pkg::*;

  localparam int VW = FRAC_BITS + 1;
  localparam int CW = (FRAC_BITS + 2 > MW + 2) ? FRAC_BITS + 2 : MW + 2;
  localparam int EW = (IW > VW) ? IW : VW;
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  logic                v1, v2, v3, v4;
  logic                rdy1, rdy2, rdy3, rdy4;
  logic [3:0][MW:0]    mm1;
  logic [MW:0]         sh1;
  logic                stop1, pub1, stop2, pub2, stop3, pub3;
  logic [3:0][VW-1:0]  c2, o3;

  logic signed [MW:0]   qs [4];
  logic signed [MW:0]   lo01, lo23;
  logic [3:0][MW:0]     mm_next;
  logic [MW:0]          sh_next;
  logic                 do_shift;
  logic signed [CW-1:0] v [4];
  logic [3:0][VW-1:0]   c_next, o_next;
  logic [VW-1:0]        idle_c;
  logic [2*VW-1:0]      prod [4];
  logic [VW+1:0]        sum;
  logic [VW-1:0]        big01, big23, big;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v2 || rdy2 ? (!v1 || rdy2) : !v1;
  assign in_ready = rdy1;

  // Restore quotient sign, pick scaled or plain mixes and the shift
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qs[i] = in_data.side.neg[i] ? $signed(~{1'b0, in_data.q[i]})
                                  : $signed({1'b0, in_data.q[i]});
      mm_next[i] = in_data.side.scale ? qs[i]
                                      : (MW+1)'($signed(in_data.side.m[i]));
    end
    lo01    = (qs[0] < qs[1]) ? qs[0] : qs[1];
    lo23    = (qs[2] < qs[3]) ? qs[2] : qs[3];
    sh_next = in_data.side.scale ? ((lo01 < lo23) ? lo01 : lo23)
                                 : in_data.side.shift_plain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      mm1   <= mm_next;
      sh1   <= sh_next;
      stop1 <= in_data.side.stop;
      pub1  <= in_data.side.pub;
    end
  end

  // Apply the shift and clamp to 0..one
  always_comb begin
    do_shift = ($signed(sh1) > 0) || (allow_raise && (sh1 != '0));
    for (int i = 0; i < 4; i++) begin
      v[i] = CW'($signed(mm1[i]));
      if (do_shift) begin
        v[i] = v[i] - CW'($signed(sh1));
      end
      if (v[i] < 0) begin
        c_next[i] = '0;
      end else if (v[i] > $signed(CW'(ONE))) begin
        c_next[i] = ONE;
      end else begin
        c_next[i] = VW'(v[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      c2    <= c_next;
      stop2 <= stop1;
      pub2  <= pub1;
    end
  end

  // Map onto idle..one
  always_comb begin
    idle_c = (EW'(idle_level) > EW'(ONE)) ? ONE : VW'(idle_level);
    for (int i = 0; i < 4; i++) begin
      prod[i]   = c2[i] * (2*VW)'(ONE - idle_c);
      o_next[i] = idle_c + VW'(prod[i] >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      o3    <= o_next;
      stop3 <= stop2;
      pub3  <= pub2;
    end
  end

  // Mean and largest motor, then the output register
  always_comb begin
    sum   = (VW+2)'(o3[0]) + (VW+2)'(o3[1]) + (VW+2)'(o3[2]) + (VW+2)'(o3[3]);
    big01 = (o3[0] > o3[1]) ? o3[0] : o3[1];
    big23 = (o3[2] > o3[3]) ? o3[2] : o3[3];
    big   = (big01 > big23) ? big01 : big23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4) begin
      out_data.publish <= pub3;
      if (stop3) begin
        out_data.front_right    <= '0;
        out_data.front_left     <= '0;
        out_data.back_right     <= '0;
        out_data.back_left      <= '0;
        out_data.average_thrust <= '0;
        out_data.largest_motor  <= '0;
      end else begin
        out_data.front_right    <= IW'(o3[0]);
        out_data.front_left     <= IW'(o3[1]);
        out_data.back_right     <= IW'(o3[2]);
        out_data.back_left      <= IW'(o3[3]);
        out_data.average_thrust <= IW'(sum >> 2);
        out_data.largest_motor  <= IW'(big);
      end
    end
  end
  assign out_valid = v4;

endmodule

/* hw/rtl/qmm_checker.sv */
// ----------------------------------------------------------------------------
// qmm_checker
// Port-level checks on the motor mixer, bound to the top level.
// ----------------------------------------------------------------------------
module qmm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Largest motor bounds every motor
  a_largest: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[83:70] >= m_tdata[13:0] && m_tdata[83:70] >= m_tdata[27:14]
              && m_tdata[83:70] >= m_tdata[41:28] && m_tdata[83:70] >= m_tdata[55:42])
    else $error("largest motor below a motor");

  // Mean never exceeds the largest
  a_mean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[69:56] <= m_tdata[83:70])
    else $error("average above largest motor");

endmodule

bind quad_motor_mixer_scaling qmm_checker u_qmm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
